/* hdl/quaternion_vector_rotate_unit_assert.svh */
// Assertion macros shared by the rotate unit RTL.
// Each macro takes a label, the clock, the reset and the expressions to check.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define QVR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication
`define QVR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define QVR_ASSERT_IMP(label, clk, rst, ante, cons)

`define QVR_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/qvr_pkg.sv */
package qvr_pkg;

   // Operand and intermediate widths
   localparam int COORD_W   = 16;
   localparam int FRAC_BITS = 14;
   localparam int OUT_SHIFT = 2 * FRAC_BITS;
   localparam int PROD1_W   = 2 * COORD_W;                  // q * v
   localparam int P_W       = PROD1_W + 1;                  // sum of three q * v
   localparam int PROD2_W   = P_W + COORD_W;                // p * q
   localparam int R_W       = PROD2_W + 1;                  // sum of four p * q
   localparam int SHIFT_W   = R_W - OUT_SHIFT;              // rounded, before clamp
   localparam int NUM_PROD  = 12;                           // products per half
   localparam int NUM_STAGE = 5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD1_W-1:0] prod1_type;
   typedef logic signed [P_W-1:0]     p_type;
   typedef logic signed [PROD2_W-1:0] prod2_type;
   typedef logic signed [R_W-1:0]     r_type;
   typedef logic signed [SHIFT_W-1:0] shift_type;

   // Half an output LSB at scale 2^28
   localparam r_type ROUND_HALF = r_type'(64'sd1 <<< (OUT_SHIFT - 1));

   localparam coord_type COORD_MAX = coord_type'(16'sh7FFF);
   localparam coord_type COORD_MIN = coord_type'(16'sh8000);
   localparam coord_type QUAT_ONE  = coord_type'(16'sh4000);

   typedef enum logic [1:0] {
      CSR_QUAT_W,
      CSR_QUAT_X,
      CSR_QUAT_Y,
      CSR_QUAT_Z
   } csr_index_type;

   // Rounded and clamped coordinate with its saturation flag
   typedef struct packed {
      coord_type value;
      logic      clip;
   } sat_type;

endpackage

/* hdl/qvr_req_if.sv */
interface qvr_req_if;
   import qvr_pkg::*;

   logic      valid;
   logic      ready;
   coord_type vec_x;
   coord_type vec_y;
   coord_type vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

/* hdl/qvr_rsp_if.sv */
interface qvr_rsp_if;
   import qvr_pkg::*;

   logic      valid;
   logic      ready;
   coord_type rot_x;
   coord_type rot_y;
   coord_type rot_z;
   logic      clipped;

   modport source (output valid, output rot_x, output rot_y, output rot_z,
                   output clipped, input ready);
   modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                   input clipped, output ready);
endinterface

/* hdl/qvr_round_sat.sv */
module qvr_round_sat (
   input  qvr_pkg::r_type   sum_val,
   output qvr_pkg::sat_type result
);
   import qvr_pkg::*;

   shift_type shifted;
   logic      in_range;

   // Drop the fraction: the rounding half is already in the sum, so this floors
   assign shifted = shift_type'(sum_val >>> OUT_SHIFT);

   // In range when all bits above the sign of a 16-bit value agree with it
   assign in_range = (shifted[SHIFT_W-1:COORD_W-1] == '0) ||
                     (shifted[SHIFT_W-1:COORD_W-1] == '1);

   // Clamp towards the sign of the overflowing value
   always_comb begin
      result.clip = !in_range;
      if (in_range) begin
         result.value = coord_type'(shifted[COORD_W-1:0]);
      end else if (shifted[SHIFT_W-1]) begin
         result.value = COORD_MIN;
      end else begin
         result.value = COORD_MAX;
      end
   end
endmodule

/* hdl/quaternion_vector_rotate_unit.sv */
// Rotates one signed 16-bit vector per clock, unless a stalled response backs up the
// pipeline, by the quaternion held in the four csr registers (Q1.14, reset to the
// identity), computing q * (0,v) * conj(q) with exact intermediates; the result is
// scaled by |q|^2, rounded half up to 16 bits and clamped, with clipped set when any
// coordinate was clamped. Five register stages (q*v products, p sums, p*q products,
// r sums, output register) carry each request to the response, and a new transaction
// is taken every cycle while no stall reaches the first stage; each stage advances
// whenever the one after it is empty or moving, so bubbles close up and a stalled
// response holds only what is behind it.
// Write the quaternion only while no transaction is in flight.
`include "quaternion_vector_rotate_unit_assert.svh"

module quaternion_vector_rotate_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  qvr_pkg::csr_index_type csr_index,
   input  qvr_pkg::coord_type     csr_wdata,
   qvr_req_if.sink                req_chan,
   qvr_rsp_if.source              rsp_chan
);
   import qvr_pkg::*;

   // Quaternion registers
   coord_type quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;

   // Stage valid bits and advance enables
   logic [NUM_STAGE-1:0] valid_ff;
   logic [NUM_STAGE-1:0] valid_in;
   logic [NUM_STAGE-1:0] stage_ready;

   // Stage payloads
   prod1_type prod1_ff [NUM_PROD];
   prod1_type prod1_in [NUM_PROD];
   p_type     pw_ff, px_ff, py_ff, pz_ff;
   p_type     pw_in, px_in, py_in, pz_in;
   prod2_type prod2_ff [NUM_PROD];
   prod2_type prod2_in [NUM_PROD];
   r_type     rx_ff, ry_ff, rz_ff;
   r_type     rx_in, ry_in, rz_in;
   coord_type rot_x_ff, rot_y_ff, rot_z_ff;
   logic      clipped_ff;
   sat_type   sat_x, sat_y, sat_z;

   // Write quaternion registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= QUAT_ONE;
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUAT_W: quat_w_ff <= csr_wdata;
            CSR_QUAT_X: quat_x_ff <= csr_wdata;
            CSR_QUAT_Y: quat_y_ff <= csr_wdata;
            CSR_QUAT_Z: quat_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance a stage when it is empty or the next stage advances
   always_comb begin
      stage_ready[NUM_STAGE-1] = !valid_ff[NUM_STAGE-1] || rsp_chan.ready;
      for (int k = NUM_STAGE - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = req_chan.valid;
      for (int k = 1; k < NUM_STAGE; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_chan.ready = stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGE; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stage 0: the twelve q * v products
   always_comb begin
      prod1_in[0]  = prod1_type'(quat_x_ff) * prod1_type'(req_chan.vec_x);
      prod1_in[1]  = prod1_type'(quat_y_ff) * prod1_type'(req_chan.vec_y);
      prod1_in[2]  = prod1_type'(quat_z_ff) * prod1_type'(req_chan.vec_z);
      prod1_in[3]  = prod1_type'(quat_w_ff) * prod1_type'(req_chan.vec_x);
      prod1_in[4]  = prod1_type'(quat_y_ff) * prod1_type'(req_chan.vec_z);
      prod1_in[5]  = prod1_type'(quat_z_ff) * prod1_type'(req_chan.vec_y);
      prod1_in[6]  = prod1_type'(quat_w_ff) * prod1_type'(req_chan.vec_y);
      prod1_in[7]  = prod1_type'(quat_z_ff) * prod1_type'(req_chan.vec_x);
      prod1_in[8]  = prod1_type'(quat_x_ff) * prod1_type'(req_chan.vec_z);
      prod1_in[9]  = prod1_type'(quat_w_ff) * prod1_type'(req_chan.vec_z);
      prod1_in[10] = prod1_type'(quat_x_ff) * prod1_type'(req_chan.vec_y);
      prod1_in[11] = prod1_type'(quat_y_ff) * prod1_type'(req_chan.vec_x);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         prod1_ff <= prod1_in;
      end
   end

   // Stage 1: p = q * (0, v)
   always_comb begin
      pw_in = -p_type'(prod1_ff[0]) - p_type'(prod1_ff[1])  - p_type'(prod1_ff[2]);
      px_in =  p_type'(prod1_ff[3]) + p_type'(prod1_ff[4])  - p_type'(prod1_ff[5]);
      py_in =  p_type'(prod1_ff[6]) + p_type'(prod1_ff[7])  - p_type'(prod1_ff[8]);
      pz_in =  p_type'(prod1_ff[9]) + p_type'(prod1_ff[10]) - p_type'(prod1_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         pw_ff <= pw_in;
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
   end

   // Stage 2: the twelve p * q products for the vector part of p * conj(q)
   always_comb begin
      prod2_in[0]  = prod2_type'(pw_ff) * prod2_type'(quat_x_ff);
      prod2_in[1]  = prod2_type'(px_ff) * prod2_type'(quat_w_ff);
      prod2_in[2]  = prod2_type'(py_ff) * prod2_type'(quat_z_ff);
      prod2_in[3]  = prod2_type'(pz_ff) * prod2_type'(quat_y_ff);
      prod2_in[4]  = prod2_type'(pw_ff) * prod2_type'(quat_y_ff);
      prod2_in[5]  = prod2_type'(px_ff) * prod2_type'(quat_z_ff);
      prod2_in[6]  = prod2_type'(py_ff) * prod2_type'(quat_w_ff);
      prod2_in[7]  = prod2_type'(pz_ff) * prod2_type'(quat_x_ff);
      prod2_in[8]  = prod2_type'(pw_ff) * prod2_type'(quat_z_ff);
      prod2_in[9]  = prod2_type'(px_ff) * prod2_type'(quat_y_ff);
      prod2_in[10] = prod2_type'(py_ff) * prod2_type'(quat_x_ff);
      prod2_in[11] = prod2_type'(pz_ff) * prod2_type'(quat_w_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         prod2_ff <= prod2_in;
      end
   end

   // Stage 3: r sums with the rounding half folded in
   always_comb begin
      rx_in = -r_type'(prod2_ff[0]) + r_type'(prod2_ff[1])
              - r_type'(prod2_ff[2]) + r_type'(prod2_ff[3]) + ROUND_HALF;
      ry_in = -r_type'(prod2_ff[4]) + r_type'(prod2_ff[5])
              + r_type'(prod2_ff[6]) - r_type'(prod2_ff[7]) + ROUND_HALF;
      rz_in = -r_type'(prod2_ff[8]) - r_type'(prod2_ff[9])
              + r_type'(prod2_ff[10]) + r_type'(prod2_ff[11]) + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rz_ff <= rz_in;
      end
   end

   // Stage 4: round, clamp and hold for the response
   qvr_round_sat u_sat_x (.sum_val(rx_ff), .result(sat_x));
   qvr_round_sat u_sat_y (.sum_val(ry_ff), .result(sat_y));
   qvr_round_sat u_sat_z (.sum_val(rz_ff), .result(sat_z));

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         rot_x_ff   <= sat_x.value;
         rot_y_ff   <= sat_y.value;
         rot_z_ff   <= sat_z.value;
         clipped_ff <= sat_x.clip | sat_y.clip | sat_z.clip;
      end
   end

   assign rsp_chan.valid   = valid_ff[NUM_STAGE-1];
   assign rsp_chan.rot_x   = rot_x_ff;
   assign rsp_chan.rot_y   = rot_y_ff;
   assign rsp_chan.rot_z   = rot_z_ff;
   assign rsp_chan.clipped = clipped_ff;

   // An accepted transaction occupies the first stage next cycle
   `QVR_ASSERT_NXT(a_accept_fills_first, clock, reset,
      req_chan.valid && req_chan.ready, valid_ff[0])

   // A blocked stage keeps its transaction
   `QVR_ASSERT_NXT(a_blocked_stage_holds, clock, reset,
      valid_ff[3] && !stage_ready[3], valid_ff[3])

   // A full pipeline with a stalled response takes no new request
   `QVR_ASSERT_IMP(a_full_stalls_input, clock, reset,
      (&valid_ff) && !rsp_chan.ready, !req_chan.ready)

   // The clipped flag marks a coordinate at a limit
   `QVR_ASSERT_IMP(a_clip_at_limit, clock, reset,
      rsp_chan.valid && rsp_chan.clipped,
      rot_x_ff == COORD_MAX || rot_x_ff == COORD_MIN ||
      rot_y_ff == COORD_MAX || rot_y_ff == COORD_MIN ||
      rot_z_ff == COORD_MAX || rot_z_ff == COORD_MIN)

endmodule
